// ----- design/dqne_pkg.sv -----
// Shared constants, codes and command/status types for the DNS query name encoder.
// No dependencies; imported by every module of the block except dqne_ram.
`default_nettype none
package dqne_pkg;

    localparam int MAX_LABEL    = 63;
    localparam int MSG_CAPACITY = 512;
    localparam int COUNT_MAX    = 1023;

    localparam int CNT_W  = 10;
    localparam int LBL_W  = $clog2(MAX_LABEL + 1);
    localparam int LBL_AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int IDX_W  = (LBL_W > 4) ? LBL_W : 4;

    localparam int HEADER_BYTES  = 12;
    localparam int TRAILER_BYTES = 5;

    localparam logic [7:0] DOT_CHAR = 8'd46;
    localparam logic [7:0] END_CHAR = 8'd0;

    // character kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DOT  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // byte sources
    localparam logic [1:0] SRC_HDR = 2'd0;
    localparam logic [1:0] SRC_LEN = 2'd1;
    localparam logic [1:0] SRC_LBL = 2'd2;
    localparam logic [1:0] SRC_TRL = 2'd3;

    // register indexes
    localparam logic [1:0] REG_QUERY_ID    = 2'd0;
    localparam logic [1:0] REG_RECURSION   = 2'd1;
    localparam logic [1:0] REG_QUERY_TYPE  = 2'd2;
    localparam logic [1:0] REG_QUERY_CLASS = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_LABEL    = 2'd1;
    localparam logic [1:0] ERR_CAPACITY = 2'd2;

    typedef struct packed {
        logic              emit;
        logic              last;
        logic [1:0]        src;
        logic [IDX_W-1:0]  idx;
        logic [LBL_AW-1:0] rd_addr;
        logic              take_char;
        logic              clr_label;
    } dqne_cmd_t;

    typedef struct packed {
        logic             out_free;
        logic [LBL_W-1:0] label_len;
        logic [1:0]       char_kind;
    } dqne_stat_t;

endpackage
`default_nettype wire

// ----- design/dqne_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dqne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- design/dqne_ctrl.sv -----
// Sequencer for the query name encoder: walks header, label and trailer bytes.
// Depends on dqne_pkg; drives dqne_dp through dqne_cmd_t.
`default_nettype none
module dqne_ctrl
    import dqne_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dqne_stat_t stat,
    output dqne_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HDR   = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_LBL   = 3'd3;
    localparam logic [2:0] ST_TRL   = 3'd4;

    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HEADER_BYTES - 1);
    localparam logic [IDX_W-1:0] TRL_LAST = IDX_W'(TRAILER_BYTES - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       kind_reg, kind_next;
    logic             hdr_sent_reg, hdr_sent_next;
    logic             take;
    logic             adv;
    logic             lbl_done;
    logic [IDX_W-1:0] idx_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;
    assign adv      = stat.out_free;
    assign idx_inc  = idx_reg + IDX_W'(1);
    assign lbl_done = (idx_inc == IDX_W'(stat.label_len));

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        kind_next     = kind_reg;
        hdr_sent_next = hdr_sent_reg;
        cmd           = '0;
        cmd.take_char = take;
        cmd.idx       = idx_reg;
        cmd.rd_addr   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    kind_next = stat.char_kind;
                    idx_next  = '0;
                    if (!hdr_sent_reg) begin
                        hdr_sent_next = 1'b1;
                        state_next    = ST_HDR;
                    end else if (stat.char_kind != KIND_CHAR) begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_HDR: begin
                cmd.src  = SRC_HDR;
                cmd.emit = adv;
                if (adv) begin
                    idx_next = idx_inc;
                    if (idx_reg == HDR_LAST) begin
                        idx_next   = '0;
                        state_next = (kind_reg == KIND_CHAR) ? ST_IDLE : ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                cmd.src  = SRC_LEN;
                cmd.emit = adv;
                if (adv) begin
                    idx_next = '0;
                    if (stat.label_len == '0) begin
                        cmd.clr_label = 1'b1;
                        state_next    = (kind_reg == KIND_END) ? ST_TRL : ST_IDLE;
                    end else begin
                        state_next = ST_LBL;
                    end
                end
            end
            ST_LBL: begin
                cmd.src     = SRC_LBL;
                cmd.emit    = adv;
                cmd.rd_addr = (adv && !lbl_done) ? LBL_AW'(idx_inc) : LBL_AW'(idx_reg);
                if (adv) begin
                    idx_next = idx_inc;
                    if (lbl_done) begin
                        idx_next      = '0;
                        cmd.clr_label = 1'b1;
                        state_next    = (kind_reg == KIND_END) ? ST_TRL : ST_IDLE;
                    end
                end
            end
            ST_TRL: begin
                cmd.src  = SRC_TRL;
                cmd.emit = adv;
                cmd.last = (idx_reg == TRL_LAST);
                if (adv) begin
                    idx_next = idx_inc;
                    if (idx_reg == TRL_LAST) begin
                        idx_next      = '0;
                        hdr_sent_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            kind_reg     <= KIND_CHAR;
            hdr_sent_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            kind_reg     <= kind_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/dqne_dp.sv -----
// Datapath: config registers, label store, byte source mux, byte pairing
// and output register. Depends on dqne_pkg and dqne_ram.
`default_nettype none
module dqne_dp
    import dqne_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    input  wire logic [7:0]  s_tdata,
    output logic      [31:0] m_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                        // [17:16] byte_count, [27:18] message_length,
                                        // [29:28] error_code, [31:30] zero
    output logic             m_tvalid,
    output logic             m_tlast,   // message_end
    input  wire logic        m_tready,
    input  wire dqne_cmd_t   cmd,
    output dqne_stat_t       stat
);

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MSG_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_MAX);
    localparam logic [LBL_W-1:0] LBL_MAX = LBL_W'(MAX_LABEL);

    logic [15:0] qid_reg;
    logic        rd_reg;
    logic [15:0] qtype_reg;
    logic [15:0] qclass_reg;

    logic [LBL_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       err_reg, err_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [7:0]       pend_reg;

    logic             out_vld_reg;
    logic [7:0]       out_b0_reg, out_b1_reg;
    logic [1:0]       out_cnt_reg;
    logic             out_end_reg;
    logic [CNT_W-1:0] out_len_reg;
    logic [1:0]       out_err_reg;

    logic             cfg_wr;
    logic [1:0]       char_kind;
    logic             lbl_full;
    logic             wr_char;
    logic [7:0]       ram_rdata;
    logic [7:0]       cur_byte;
    logic [CNT_W-1:0] cnt_inc;
    logic [1:0]       err_upd;
    logic [1:0]       err_code;
    logic             out_load;
    logic             out_free;

    // configuration port
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qid_reg    <= 16'h1234;
            rd_reg     <= 1'b1;
            qtype_reg  <= 16'd1;
            qclass_reg <= 16'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_QUERY_ID:    qid_reg    <= pwdata[15:0];
                REG_RECURSION:   rd_reg     <= pwdata[0];
                REG_QUERY_TYPE:  qtype_reg  <= pwdata[15:0];
                REG_QUERY_CLASS: qclass_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_QUERY_ID:    prdata = {16'd0, qid_reg};
            REG_RECURSION:   prdata = {31'd0, rd_reg};
            REG_QUERY_TYPE:  prdata = {16'd0, qtype_reg};
            REG_QUERY_CLASS: prdata = {16'd0, qclass_reg};
            default:         prdata = '0;
        endcase
    end

    // input character
    always_comb begin
        if (s_tdata == END_CHAR) begin
            char_kind = KIND_END;
        end else if (s_tdata == DOT_CHAR) begin
            char_kind = KIND_DOT;
        end else begin
            char_kind = KIND_CHAR;
        end
    end

    assign lbl_full = (len_reg >= LBL_MAX);
    assign wr_char  = cmd.take_char && (char_kind == KIND_CHAR) && !lbl_full;

    dqne_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LABEL)
    ) u_label_ram (
        .aclk  (aclk),
        .we    (wr_char),
        .waddr (LBL_AW'(len_reg)),
        .wdata (s_tdata),
        .raddr (cmd.rd_addr),
        .rdata (ram_rdata)
    );

    // byte source
    always_comb begin
        cur_byte = 8'd0;
        case (cmd.src)
            SRC_HDR: begin
                case (cmd.idx)
                    IDX_W'(0): cur_byte = qid_reg[15:8];
                    IDX_W'(1): cur_byte = qid_reg[7:0];
                    IDX_W'(2): cur_byte = {7'd0, rd_reg};
                    IDX_W'(5): cur_byte = 8'd1;
                    default:   cur_byte = 8'd0;
                endcase
            end
            SRC_LEN: cur_byte = 8'(len_reg);
            SRC_LBL: cur_byte = ram_rdata;
            SRC_TRL: begin
                case (cmd.idx)
                    IDX_W'(1): cur_byte = qtype_reg[15:8];
                    IDX_W'(2): cur_byte = qtype_reg[7:0];
                    IDX_W'(3): cur_byte = qclass_reg[15:8];
                    IDX_W'(4): cur_byte = qclass_reg[7:0];
                    default:   cur_byte = 8'd0;
                endcase
            end
            default: cur_byte = 8'd0;
        endcase
    end

    // count and error after this byte
    assign cnt_inc = (cnt_reg < CNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign err_upd = err_reg | ((cnt_inc > CNT_CAP) ? 2'b10 : 2'b00);

    always_comb begin
        if (err_upd[1]) begin
            err_code = ERR_CAPACITY;
        end else if (err_upd[0]) begin
            err_code = ERR_LABEL;
        end else begin
            err_code = ERR_OK;
        end
    end

    assign out_free = !out_vld_reg || m_tready;
    assign out_load = cmd.emit && (pend_vld_reg || cmd.last);

    always_comb begin
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        pend_vld_next = pend_vld_reg;
        if (wr_char) begin
            len_next = len_reg + LBL_W'(1);
        end
        if (cmd.take_char && (char_kind == KIND_CHAR) && lbl_full) begin
            err_next = err_reg | 2'b01;
        end
        if (cmd.clr_label) begin
            len_next = '0;
        end
        if (cmd.emit) begin
            cnt_next      = cnt_inc;
            err_next      = err_upd;
            pend_vld_next = !pend_vld_reg && !cmd.last;
            if (cmd.last) begin
                len_next = '0;
                cnt_next = '0;
                err_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            cnt_reg      <= '0;
            err_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            err_reg      <= err_next;
            pend_vld_reg <= pend_vld_next;
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit && !pend_vld_reg) begin
            pend_reg <= cur_byte;
        end
        if (out_load) begin
            out_b0_reg  <= pend_vld_reg ? pend_reg : cur_byte;
            out_b1_reg  <= pend_vld_reg ? cur_byte : 8'd0;
            out_cnt_reg <= pend_vld_reg ? 2'd2 : 2'd1;
            out_end_reg <= cmd.last;
            out_len_reg <= cmd.last ? cnt_inc : '0;
            out_err_reg <= err_code;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_end_reg;
    assign m_tdata  = {2'b00, out_err_reg, out_len_reg, out_cnt_reg, out_b1_reg, out_b0_reg};

    assign stat.out_free  = out_free;
    assign stat.label_len = len_reg;
    assign stat.char_kind = char_kind;

endmodule
`default_nettype wire

// ----- design/dns_query_name_encoder.sv -----
// DNS query name encoder: header, length-prefixed labels and question trailer.
// A normal character is stored in the label RAM; the first item of a message adds 12 header bytes.
// Dot: 1 + L bytes, end: 6 + L bytes (L = kept label bytes), one byte per cycle
// through the label RAM read port; output stalls hold the sequencer.
// Reset (aresetn, synchronous): message state cleared, registers to defaults.
// Depends on dqne_pkg, dqne_ctrl, dqne_dp, dqne_ram.
`default_nettype none
module dns_query_name_encoder
    import dqne_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] name_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                        // [17:16] byte_count, [27:18] message_length,
                                        // [29:28] error_code, [31:30] zero
    output logic             m_tlast    // message_end
);

    dqne_cmd_t  cmd;
    dqne_stat_t stat;

    assign pready = 1'b1;

    dqne_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dqne_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for dns_query_name_encoder: streams names, predicts packed message words.
// Depends on dqne_pkg and dns_query_name_encoder.
// Covers directed corner names, random names, register settings and a directed over-long label.
module testbench;
    import dqne_pkg::*;

    typedef struct {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] cnt;
        logic       last;
        logic [9:0] len;
        logic [1:0] err;
    } enc_word_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] name_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [7:0] first, [15:8] second, [17:16] count,
                                  // [27:18] length, [29:28] error, [31:30] zero
    logic        m_tlast;         // message_end

    dns_query_name_encoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    logic [7:0] name_chars[$];
    enc_word_t  words_due[$];
    bit         no_gaps = 1'b0;
    int         mismatches = 0;
    int         chars_sent = 0;
    int         names_done = 0;
    int         words_checked = 0;
    int         random_chars = 0;

    // register shadows
    logic [15:0] cfg_id    = 16'h1234;
    logic        cfg_rd    = 1'b1;
    logic [15:0] cfg_type  = 16'd1;
    logic [15:0] cfg_class = 16'd1;

    // encoder shadow state
    logic [7:0]  lbl_buf[MAX_LABEL];
    int unsigned lbl_len = 0;
    bit          hdr_done = 1'b0;
    int unsigned byte_total = 0;
    logic [1:0]  err_bits = '0;
    bit          half_valid = 1'b0;
    logic [7:0]  half_byte = '0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [1:0] err_now();
        if (err_bits[1]) return ERR_CAPACITY;
        if (err_bits[0]) return ERR_LABEL;
        return ERR_OK;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        enc_word_t w;
        if (byte_total < COUNT_MAX) byte_total++;
        if (byte_total > MSG_CAPACITY) err_bits[1] = 1'b1;
        if (!half_valid) begin
            half_byte  = b;
            half_valid = 1'b1;
        end else begin
            w = '{b0: half_byte, b1: b, cnt: 2'd2, last: 1'b0, len: '0, err: err_now()};
            words_due.push_back(w);
            half_valid = 1'b0;
        end
    endfunction

    function automatic void flush_label();
        push_byte(8'(lbl_len));
        for (int i = 0; i < lbl_len; i++) push_byte(lbl_buf[i]);
        lbl_len = 0;
    endfunction

    function automatic void encode_char(logic [7:0] c);
        enc_word_t w;
        if (!hdr_done) begin
            push_byte(cfg_id[15:8]);
            push_byte(cfg_id[7:0]);
            push_byte({7'd0, cfg_rd});
            push_byte(8'd0);
            push_byte(8'd0);
            push_byte(8'd1);
            repeat (6) push_byte(8'd0);
            hdr_done = 1'b1;
        end
        if (c == END_CHAR) begin
            flush_label();
            push_byte(8'd0);
            push_byte(cfg_type[15:8]);
            push_byte(cfg_type[7:0]);
            push_byte(cfg_class[15:8]);
            push_byte(cfg_class[7:0]);
            if (half_valid) begin
                w = '{b0: half_byte, b1: 8'd0, cnt: 2'd1, last: 1'b1,
                      len: 10'(byte_total), err: err_now()};
                words_due.push_back(w);
            end else begin
                w = words_due.pop_back();
                w.last = 1'b1;
                w.len  = 10'(byte_total);
                w.err  = err_now();
                words_due.push_back(w);
            end
            lbl_len    = 0;
            hdr_done   = 1'b0;
            byte_total = 0;
            err_bits   = '0;
            half_valid = 1'b0;
            names_done++;
        end else if (c == DOT_CHAR) begin
            flush_label();
        end else if (lbl_len < MAX_LABEL) begin
            lbl_buf[lbl_len] = c;
            lbl_len++;
        end else begin
            err_bits[0] = 1'b1;
        end
    endfunction

    function automatic void check_field(string field, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                encode_char(s_tdata);
                chars_sent++;
            end
            if (name_chars.size() != 0 && (no_gaps || $urandom_range(99) >= 25)) begin
                s_tdata  <= name_chars.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor
    enc_word_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected output item: tdata=%h tlast=%b", m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = words_due.pop_front();
                    check_field("first_byte", want.b0, m_tdata[7:0]);
                    check_field("second_byte", want.b1, m_tdata[15:8]);
                    check_field("byte_count", want.cnt, m_tdata[17:16]);
                    check_field("message_length", want.len, m_tdata[27:18]);
                    check_field("error_code", want.err, m_tdata[29:28]);
                    check_field("pad", 0, m_tdata[31:30]);
                    check_field("message_end", want.last, m_tlast);
                    words_checked++;
                end
            end
            m_tready <= no_gaps || $urandom_range(99) >= 25;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_QUERY_ID:    cfg_id    = value[15:0];
            REG_RECURSION:   cfg_rd    = value[0];
            REG_QUERY_TYPE:  cfg_type  = value[15:0];
            REG_QUERY_CLASS: cfg_class = value[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] id, logic [31:0] rd, logic [31:0] qt, logic [31:0] qc);
        reg_write(REG_QUERY_ID, id);
        reg_write(REG_RECURSION, rd);
        reg_write(REG_QUERY_TYPE, qt);
        reg_write(REG_QUERY_CLASS, qc);
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == DOT_CHAR);
        return b;
    endfunction

    function automatic void queue_label(int unsigned len);
        repeat (len) name_chars.push_back(label_char());
    endfunction

    // mostly well-formed names; stray dots and over-long labels now and then
    function automatic void queue_name();
        int unsigned labels;
        int unsigned len;
        int unsigned start;
        start  = name_chars.size();
        labels = $urandom_range(0, 4);
        for (int l = 0; l < labels; l++) begin
            if ($urandom_range(7) == 0) name_chars.push_back(DOT_CHAR);
            len = ($urandom_range(11) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 8);
            queue_label(len);
            if (l < labels - 1) name_chars.push_back(DOT_CHAR);
        end
        if ($urandom_range(5) == 0) name_chars.push_back(DOT_CHAR);
        name_chars.push_back(END_CHAR);
        random_chars += name_chars.size() - start;
    endfunction

    task automatic drain();
        while (name_chars.size() != 0 || s_tvalid) @(posedge aclk);
        while (words_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty name; extremes, empty labels; end after dot; short name
        name_chars = '{END_CHAR,
                       8'h01, 8'hFF, DOT_CHAR, DOT_CHAR, 8'h80, 8'h2D, 8'h2F, END_CHAR,
                       8'h78, DOT_CHAR, END_CHAR,
                       DOT_CHAR, END_CHAR,
                       8'h61, 8'h62, 8'h63, DOT_CHAR, 8'h7F, 8'h40, END_CHAR};
        drain();

        set_regs(32'h0, 32'h0, 32'h0, 32'h0);
        while (random_chars < 60) queue_name();
        drain();

        set_regs(32'hFFFF, 32'h1, 32'hFFFF, 32'hFFFF);
        no_gaps <= 1'b1;
        while (random_chars < 120) queue_name();
        drain();
        no_gaps <= 1'b0;

        set_regs($urandom, $urandom, $urandom, $urandom);
        while (random_chars < 180) queue_name();
        // over-long label: excess characters dropped, label error flagged
        queue_label(66);
        name_chars.push_back(END_CHAR);
        drain();

        $display("%0d name characters in %0d names, %0d output items checked",
                 chars_sent, names_done, words_checked);
        $display("register settings: defaults, all zero, all ones, random");
        if (mismatches == 0) begin
            $display("dns_query_name_encoder verification clean");
        end else begin
            $display("dns_query_name_encoder verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("dns_query_name_encoder verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dqne_pkg.sv
design/dqne_ram.sv
design/dqne_ctrl.sv
design/dqne_dp.sv
design/dns_query_name_encoder.sv
tb/testbench.sv
